[src/ifra_pkg.sv]
// Shared types and constants for the information-frame receiver.
// Holds the register map, framing bytes, hunt phases and the queue record.
// Depends on nothing.
package ifra_pkg;

	// Framing and escape bytes.
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_FLAG  = 8'h5E;
	localparam logic [7:0] ESC_ESC   = 8'h5D;

	// Configuration register map.
	localparam int          CFG_IDX_W     = 3;
	localparam int          NUM_REGS      = 7;
	localparam logic [2:0]  REG_ADDR      = 3'd0;
	localparam logic [2:0]  REG_INFO0     = 3'd1;
	localparam logic [2:0]  REG_INFO1     = 3'd2;
	localparam logic [2:0]  REG_RDY0      = 3'd3;
	localparam logic [2:0]  REG_RDY1      = 3'd4;
	localparam logic [2:0]  REG_REJ0      = 3'd5;
	localparam logic [2:0]  REG_REJ1      = 3'd6;

	// Reply frame byte positions.
	localparam logic [2:0] RP_OPEN  = 3'd0;
	localparam logic [2:0] RP_ADDR  = 3'd1;
	localparam logic [2:0] RP_CTRL  = 3'd2;
	localparam logic [2:0] RP_CHECK = 3'd3;
	localparam logic [2:0] RP_CLOSE = 3'd4;
	localparam logic [2:0] REPLY_LEN = 3'd5;

	// Output kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPLY   = 1'b1;

	// Queue depth.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Receive hunt phases.
	typedef enum logic [2:0] {
		PH_FLAG = 3'd0,
		PH_ADDR = 3'd1,
		PH_CTRL = 3'd2,
		PH_HCHK = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	// Work record handed from the front to the back for one received byte.
	typedef struct packed {
		logic [1:0] n_pay;
		logic [7:0] pay0;
		logic [7:0] pay1;
		logic       reply;
		logic [7:0] addr;
		logic [7:0] ctrl;
	} work_t;

endpackage

[src/ifra_front.sv]
// Front part: holds the configuration registers, hunts the frame header,
// destuffs the data field and pushes a work record for each byte with output.
// Depends on ifra_pkg.
module ifra_front import ifra_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output work_t                q_rec
);

	typedef struct packed {
		logic [7:0] held;
		logic       held_v;
		logic [7:0] xsum;
		logic [1:0] n_pay;
		logic [7:0] pay0;
		logic [7:0] pay1;
	} acc_t;

	// Move a data byte into the hold slot; the previous one leaves as payload.
	function automatic acc_t take(acc_t a, logic [7:0] d);
		acc_t r;
		r = a;
		if (r.held_v) begin
			if (r.n_pay == 2'd0) r.pay0 = r.held;
			else r.pay1 = r.held;
			r.n_pay = r.n_pay + 2'd1;
			r.xsum  = r.xsum ^ r.held;
		end
		r.held   = d;
		r.held_v = 1'b1;
		return r;
	endfunction

	logic [7:0] cfg_q [NUM_REGS];
	phase_t     phase_q, phase_d;
	logic       seq_q, seq_d;
	logic       esc_q, esc_d;
	logic [7:0] held_q;
	logic       held_v_q;
	logic [7:0] xsum_q;
	acc_t       acc;
	logic       rep;
	logic [7:0] rep_ctrl;
	logic       do_data;
	logic       good;
	logic       accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_ADDR]  <= 8'd3;
			cfg_q[REG_INFO0] <= 8'd0;
			cfg_q[REG_INFO1] <= 8'd64;
			cfg_q[REG_RDY0]  <= 8'd5;
			cfg_q[REG_RDY1]  <= 8'd133;
			cfg_q[REG_REJ0]  <= 8'd1;
			cfg_q[REG_REJ1]  <= 8'd129;
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Next state and work record for the byte at the input.
	always_comb begin
		phase_d    = phase_q;
		seq_d      = seq_q;
		esc_d      = esc_q;
		acc.held   = held_q;
		acc.held_v = held_v_q;
		acc.xsum   = xsum_q;
		acc.n_pay  = 2'd0;
		acc.pay0   = 8'd0;
		acc.pay1   = 8'd0;
		rep        = 1'b0;
		rep_ctrl   = 8'd0;
		do_data    = 1'b0;
		good       = 1'b0;
		unique case (phase_q)
			PH_ADDR: begin
				if (rx_byte == cfg_q[REG_ADDR]) phase_d = PH_CTRL;
				else if (rx_byte == FLAG_BYTE) phase_d = PH_ADDR;
				else phase_d = PH_FLAG;
			end
			PH_CTRL: begin
				if (rx_byte == cfg_q[REG_INFO0]) begin
					seq_d   = 1'b0;
					phase_d = PH_HCHK;
				end else if (rx_byte == cfg_q[REG_INFO1]) begin
					seq_d   = 1'b1;
					phase_d = PH_HCHK;
				end else if (rx_byte == FLAG_BYTE) begin
					phase_d = PH_ADDR;
				end else begin
					phase_d = PH_FLAG;
				end
			end
			PH_HCHK: begin
				if (rx_byte == (cfg_q[REG_ADDR] ^
						(seq_q ? cfg_q[REG_INFO1] : cfg_q[REG_INFO0]))) begin
					esc_d      = 1'b0;
					acc.held   = 8'd0;
					acc.held_v = 1'b0;
					acc.xsum   = 8'd0;
					phase_d    = PH_DATA;
				end else begin
					phase_d = PH_FLAG;
				end
			end
			PH_DATA: begin
				// Resolve a pending escape first.
				if (esc_q) begin
					esc_d = 1'b0;
					if (rx_byte == ESC_FLAG) begin
						acc = take(acc, FLAG_BYTE);
					end else if (rx_byte == ESC_ESC) begin
						acc = take(acc, ESC_BYTE);
					end else begin
						acc     = take(acc, ESC_BYTE);
						do_data = 1'b1;
					end
				end else begin
					do_data = 1'b1;
				end
				// Plain data byte handling, including the closing flag.
				if (do_data) begin
					if (rx_byte == FLAG_BYTE) begin
						good = acc.held_v && (acc.held == acc.xsum);
						if (good) rep_ctrl = seq_q ? cfg_q[REG_RDY0] : cfg_q[REG_RDY1];
						else rep_ctrl = seq_q ? cfg_q[REG_REJ1] : cfg_q[REG_REJ0];
						rep        = 1'b1;
						esc_d      = 1'b0;
						acc.held   = 8'd0;
						acc.held_v = 1'b0;
						acc.xsum   = 8'd0;
						phase_d    = PH_FLAG;
					end else if (rx_byte == ESC_BYTE) begin
						esc_d = 1'b1;
					end else begin
						acc = take(acc, rx_byte);
					end
				end
			end
			default: begin
				phase_d = (rx_byte == FLAG_BYTE) ? PH_ADDR : PH_FLAG;
			end
		endcase
	end

	// Work record to the queue; bytes that yield no output push nothing.
	always_comb begin
		q_rec.n_pay = acc.n_pay;
		q_rec.pay0  = acc.pay0;
		q_rec.pay1  = acc.pay1;
		q_rec.reply = rep;
		q_rec.addr  = cfg_q[REG_ADDR];
		q_rec.ctrl  = rep_ctrl;
		q_push      = accept && ((acc.n_pay != 2'd0) || rep);
	end

	// Receive state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FLAG;
			seq_q    <= 1'b0;
			esc_q    <= 1'b0;
			held_q   <= 8'd0;
			held_v_q <= 1'b0;
			xsum_q   <= 8'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			seq_q    <= seq_d;
			esc_q    <= esc_d;
			held_q   <= acc.held;
			held_v_q <= acc.held_v;
			xsum_q   <= acc.xsum;
		end
	end

endmodule

[src/ifra_queue.sv]
// Short work queue between the front and the back of the receiver.
// Holds up to QDEPTH work records; push and pop may happen together.
// Depends on ifra_pkg.
module ifra_queue import ifra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_rec,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output work_t pop_rec
);

	work_t             mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_rec = mem[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= push_rec;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

[src/ifra_back.sv]
// Back part: expands each work record into payload and reply bytes and
// drives the registered output, one byte per cycle unless stalled.
// Depends on ifra_pkg.
module ifra_back import ifra_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  work_t      q_rec,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic       out_last
);

	work_t      cur_q;
	logic       cur_v_q;
	logic [2:0] step_q;
	logic [2:0] total;
	logic [2:0] rpos;
	logic       in_reply;
	logic       advance;
	logic       final_step;
	logic       b_kind;
	logic [7:0] b_byte;
	logic       b_last;
	logic       out_v_q;
	logic       kind_q;
	logic [7:0] byte_q;
	logic       last_q;

	// Byte count of the current record and the byte at the current step.
	always_comb begin
		total      = {1'b0, cur_q.n_pay} + (cur_q.reply ? REPLY_LEN : 3'd0);
		in_reply   = (step_q >= {1'b0, cur_q.n_pay});
		rpos       = step_q - {1'b0, cur_q.n_pay};
		final_step = (step_q == total - 3'd1);
		b_last     = 1'b0;
		b_kind     = KIND_PAYLOAD;
		b_byte     = (step_q == 3'd0) ? cur_q.pay0 : cur_q.pay1;
		if (in_reply) begin
			b_kind = KIND_REPLY;
			unique case (rpos)
				RP_OPEN:  b_byte = FLAG_BYTE;
				RP_ADDR:  b_byte = cur_q.addr;
				RP_CTRL:  b_byte = cur_q.ctrl;
				RP_CHECK: b_byte = cur_q.addr ^ cur_q.ctrl;
				default: begin
					b_byte = FLAG_BYTE;
					b_last = 1'b1;
				end
			endcase
		end
	end

	assign advance = cur_v_q && (!out_v_q || out_ready);
	assign q_pop   = !q_empty && (!cur_v_q || (advance && final_step));

	// Current record and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			step_q  <= 3'd0;
		end else if (q_pop) begin
			cur_v_q <= 1'b1;
			step_q  <= 3'd0;
		end else if (advance) begin
			if (final_step) begin
				cur_v_q <= 1'b0;
				step_q  <= 3'd0;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_rec;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= b_kind;
			byte_q <= b_byte;
			last_q <= b_last;
		end
	end

	assign out_valid = out_v_q;
	assign out_kind  = kind_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule

[src/info_frame_receiver_ack.sv]
// Information-frame receiver top level: one received byte per cycle in.
// Results pass the queue, the current-record register and the output register.
// Throughput: one input byte per cycle while the four-record queue has room;
// output one byte per cycle unless stalled; a closing flag (up to six bytes) paces it.
// Reset (arst_n low) clears the hunt state, queue and output valid and loads
// the register defaults; no clearing pass is needed.
module info_frame_receiver_ack import ifra_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_kind,
	output logic [7:0]           out_byte,
	output logic                 out_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	work_t push_rec;
	work_t pop_rec;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;

	// Header hunt and destuffing.
	ifra_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (full),
		.q_push    (push),
		.q_rec     (push_rec)
	);

	// Decoupling queue.
	ifra_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.pop_rec  (pop_rec)
	);

	// Output sequencer.
	ifra_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_rec     (pop_rec),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

[src/ifra_checker.sv]
// Port-level checks for the information-frame receiver, bound to the top level.
// Depends on ifra_pkg.
module ifra_checker import ifra_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_kind,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       cfg_ready
);

	// A stalled output transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(out_kind) && $stable(out_last))
		else $error("output changed while stalled");

	// Only a reply byte can end a frame's results.
	a_last_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_kind == KIND_REPLY)
		else $error("last flag on a payload byte");

	// The final reply byte is the closing flag.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_byte == FLAG_BYTE)
		else $error("final reply byte is not a flag");

	// A reply byte that directly follows a completed reply must be the opening flag.
	a_reply_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last ##1 out_valid && out_kind == KIND_REPLY
		|-> out_byte == FLAG_BYTE)
		else $error("reply frame does not open with a flag");

	// The configuration port never stalls.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind info_frame_receiver_ack ifra_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_kind  (out_kind),
	.out_byte  (out_byte),
	.out_last  (out_last),
	.cfg_ready (cfg_ready)
);

[tb/ifra_test_pkg.sv]
// Scoreboard for the information-frame receiver testbench: a predictor of payload and reply
// bytes with its own copy of the registers and hunt state, and the store of expected bytes.
// Depends on ifra_pkg for the register map, framing bytes, phases and output kinds.
package ifra_test_pkg;
	import ifra_pkg::*;

	// One expected output transaction.
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} out_byte_t;

	class rx_frame_scoreboard;
		logic [7:0] regs [NUM_REGS];
		phase_t     phase;
		logic       seq;
		logic       esc_pending;
		logic       held_valid;
		logic [7:0] held;
		logic [7:0] xsum;
		out_byte_t  pending_bytes [$];
		int         errors;

		function new();
			regs[REG_ADDR]  = 8'd3;
			regs[REG_INFO0] = 8'd0;
			regs[REG_INFO1] = 8'd64;
			regs[REG_RDY0]  = 8'd5;
			regs[REG_RDY1]  = 8'd133;
			regs[REG_REJ0]  = 8'd1;
			regs[REG_REJ1]  = 8'd129;
			phase = PH_FLAG;
			seq = 1'b0;
			clear_frame();
			errors = 0;
		endfunction

		// Indexes past the last register are dropped by the block.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			if (idx < NUM_REGS)
				regs[idx] = val;
		endfunction

		function int pending();
			return pending_bytes.size();
		endfunction

		function void push(logic kind, logic [7:0] data, logic last);
			out_byte_t item;
			item.kind = kind;
			item.data = data;
			item.last = last;
			pending_bytes.push_back(item);
		endfunction

		function void clear_frame();
			esc_pending = 1'b0;
			held = 8'h00;
			held_valid = 1'b0;
			xsum = 8'h00;
		endfunction

		// Payload goes out one byte late, so the final data byte is held back as BCC2.
		function void take_data(logic [7:0] d);
			if (held_valid) begin
				push(KIND_PAYLOAD, held, 1'b0);
				xsum = xsum ^ held;
			end
			held = d;
			held_valid = 1'b1;
		endfunction

		// Closing flag: RR for the other sequence on a good check, otherwise REJ.
		function void close_frame();
			logic       good;
			logic [7:0] addr;
			logic [7:0] ctrl;
			addr = regs[REG_ADDR];
			good = held_valid && (held == xsum);
			if (good)
				ctrl = seq ? regs[REG_RDY0] : regs[REG_RDY1];
			else
				ctrl = seq ? regs[REG_REJ1] : regs[REG_REJ0];
			push(KIND_REPLY, FLAG_BYTE, 1'b0);
			push(KIND_REPLY, addr, 1'b0);
			push(KIND_REPLY, ctrl, 1'b0);
			push(KIND_REPLY, addr ^ ctrl, 1'b0);
			push(KIND_REPLY, FLAG_BYTE, 1'b1);
			clear_frame();
			phase = PH_FLAG;
		endfunction

		function void data_byte(logic [7:0] b);
			if (b == FLAG_BYTE)
				close_frame();
			else if (b == ESC_BYTE)
				esc_pending = 1'b1;
			else
				take_data(b);
		endfunction

		// Advance the predicted receiver by one accepted input transaction.
		function void note_rx_byte(logic [7:0] b);
			logic [7:0] ctrl;
			case (phase)
				PH_ADDR: begin
					if (b == regs[REG_ADDR])
						phase = PH_CTRL;
					else if (b == FLAG_BYTE)
						phase = PH_ADDR;
					else
						phase = PH_FLAG;
				end
				PH_CTRL: begin
					if (b == regs[REG_INFO0]) begin
						seq = 1'b0;
						phase = PH_HCHK;
					end else if (b == regs[REG_INFO1]) begin
						seq = 1'b1;
						phase = PH_HCHK;
					end else if (b == FLAG_BYTE) begin
						phase = PH_ADDR;
					end else begin
						phase = PH_FLAG;
					end
				end
				PH_HCHK: begin
					ctrl = seq ? regs[REG_INFO1] : regs[REG_INFO0];
					if (b == (regs[REG_ADDR] ^ ctrl)) begin
						clear_frame();
						phase = PH_DATA;
					end else begin
						phase = PH_FLAG;
					end
				end
				PH_DATA: begin
					if (esc_pending) begin
						esc_pending = 1'b0;
						if (b == ESC_FLAG) begin
							take_data(FLAG_BYTE);
						end else if (b == ESC_ESC) begin
							take_data(ESC_BYTE);
						end else begin
							// A lone escape is data; the following byte is seen afresh.
							take_data(ESC_BYTE);
							data_byte(b);
						end
					end else begin
						data_byte(b);
					end
				end
				default: begin
					phase = (b == FLAG_BYTE) ? PH_ADDR : PH_FLAG;
				end
			endcase
		endfunction

		// Compare one output transaction against the oldest expected byte.
		function void check_output(logic kind, logic [7:0] data, logic last);
			out_byte_t want;
			if (pending_bytes.size() == 0) begin
				$error("unexpected output transaction: out_kind %0d out_byte %02h out_last %0d",
					kind, data, last);
				errors++;
				return;
			end
			want = pending_bytes.pop_front();
			if (kind !== want.kind) begin
				$error("out_kind: expected %0d, actual %0d", want.kind, kind);
				errors++;
			end
			if (data !== want.data) begin
				$error("out_byte: expected %02h, actual %02h", want.data, data);
				errors++;
			end
			if (last !== want.last) begin
				$error("out_last: expected %0d, actual %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

endpackage

[tb/info_frame_receiver_ack_test.sv]
// Top of the information-frame receiver testbench: drives stuffed frames, noise and register
// settings through the handshakes and checks every output byte against the scoreboard.
// Depends on ifra_pkg, ifra_test_pkg and the info_frame_receiver_ack RTL.
module info_frame_receiver_ack_test;
	import ifra_pkg::*;
	import ifra_test_pkg::*;

	localparam logic [CFG_IDX_W-1:0] SPARE_INDEX = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 out_kind;
	logic [7:0]           out_byte;
	logic                 out_last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = 8'h00;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned sent_count = 0;
	logic [7:0]  cur_cfg [NUM_REGS] = '{8'd3, 8'd0, 8'd64, 8'd5, 8'd133, 8'd1, 8'd129};
	logic [7:0]  line_q [$];
	rx_frame_scoreboard sb;

	info_frame_receiver_ack i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver side stalls at random according to the current idling phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watch all three channels and feed each transaction to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_rx_byte(rx_byte);
			if (out_valid && out_ready)
				sb.check_output(out_kind, out_byte, out_last);
		end
	end

	// Valid stays high across back-to-back bytes; it drops only for an idle gap.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	task automatic send_line();
		while (line_q.size() > 0)
			send_byte(line_q.pop_front());
	endtask

	// Hold the sender until every expected byte is out, then let the pipeline settle.
	// The first edge lets the monitor record the last accepted input transaction.
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_all_regs(input bit with_spare);
		int i;
		for (i = 0; i < NUM_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= cur_cfg[i];
			do @(posedge clk); while (!cfg_ready);
		end
		if (with_spare) begin
			cfg_index <= SPARE_INDEX;
			cfg_data <= 8'($urandom_range(255));
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Data bytes lean toward the flag, escape and escape-suffix values and the extremes.
	function automatic logic [7:0] pick_data();
		case ($urandom_range(7))
			0: return FLAG_BYTE;
			1: return ESC_BYTE;
			2: return ESC_FLAG;
			3: return ESC_ESC;
			4: return $urandom_range(1) ? 8'hFF : 8'h00;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void add_stuffed(input logic [7:0] d);
		if (d == FLAG_BYTE) begin
			line_q.push_back(ESC_BYTE);
			line_q.push_back(ESC_FLAG);
		end else if (d == ESC_BYTE) begin
			line_q.push_back(ESC_BYTE);
			line_q.push_back(ESC_ESC);
		end else begin
			line_q.push_back(d);
		end
	endfunction

	// Mostly well-formed frames with random payload; some noise, broken headers,
	// bad checks, lone escapes and missing closing flags.
	task automatic send_random_frame();
		int unsigned roll;
		int unsigned len;
		int unsigned i;
		logic [7:0]  addr;
		logic [7:0]  ctrl;
		logic [7:0]  bcc;
		logic [7:0]  d;
		roll = $urandom_range(99);
		if (roll < 8) begin
			repeat ($urandom_range(1, 4)) line_q.push_back(pick_data());
		end else begin
			addr = cur_cfg[REG_ADDR];
			ctrl = $urandom_range(1) ? cur_cfg[REG_INFO1] : cur_cfg[REG_INFO0];
			if ($urandom_range(9) == 0)
				line_q.push_back(FLAG_BYTE);
			line_q.push_back(FLAG_BYTE);
			line_q.push_back((roll < 11) ? pick_data() : addr);
			line_q.push_back((roll >= 11 && roll < 14) ? pick_data() : ctrl);
			line_q.push_back((roll >= 14 && roll < 17) ? pick_data() : (addr ^ ctrl));
			len = ($urandom_range(11) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
			bcc = 8'h00;
			for (i = 0; i < len; i++) begin
				d = pick_data();
				bcc = bcc ^ d;
				add_stuffed(d);
				if ($urandom_range(29) == 0) begin
					line_q.push_back(ESC_BYTE);
					line_q.push_back(pick_data());
				end
			end
			// An empty data field may leave out the check byte as well.
			if (len > 0 || $urandom_range(1)) begin
				if ($urandom_range(3) == 0)
					bcc = 8'($urandom_range(255));
				add_stuffed(bcc);
			end
			if ($urandom_range(14) == 0)
				line_q.push_back(ESC_BYTE);
			if ($urandom_range(19) != 0)
				line_q.push_back(FLAG_BYTE);
		end
		send_line();
	endtask

	// Run limit far above the slowest correct run.
	initial begin
		#2000000;
		$display("info_frame_receiver_ack_test: errors");
		$finish;
	end

	initial begin
		int p;
		int unsigned target;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset registers: flags while hunting address and
		// control, every escape form, a good frame, an empty one and escape then flag.
		line_q = '{FLAG_BYTE, FLAG_BYTE, 8'h03, FLAG_BYTE, 8'h03, 8'h40, 8'h43,
			ESC_BYTE, ESC_FLAG, ESC_BYTE, ESC_ESC, ESC_BYTE, 8'hFF, 8'h81, FLAG_BYTE,
			FLAG_BYTE, 8'h03, 8'h00, 8'h03, FLAG_BYTE,
			FLAG_BYTE, 8'h03, 8'h00, 8'h03, ESC_BYTE, FLAG_BYTE};
		send_line();
		wait_drain();

		// Register settings and idling change together from phase to phase.
		for (p = 0; p < 5; p++) begin
			case (p)
				2: cur_cfg = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
				3: cur_cfg = '{8'hFF, 8'h00, 8'h7E, 8'hFF, 8'h00, 8'hFF, 8'h7D};
				default: begin
					foreach (cur_cfg[i])
						cur_cfg[i] = 8'($urandom_range(255));
				end
			endcase
			write_all_regs(p == 2);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			target = sent_count + 30;
			while (sent_count < target)
				send_random_frame();
			wait_drain();
			target = sent_count + 30;
			while (sent_count < target)
				send_random_frame();
			wait_drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("info_frame_receiver_ack_test: clean");
		else
			$display("info_frame_receiver_ack_test: errors");
		$finish;
	end

endmodule

[info_frame_receiver_ack.f]
src/ifra_pkg.sv
src/ifra_front.sv
src/ifra_queue.sv
src/ifra_back.sv
src/info_frame_receiver_ack.sv
src/ifra_checker.sv
tb/ifra_test_pkg.sv
tb/info_frame_receiver_ack_test.sv
